FILE: rtl/core/bdqt_pkg.sv
// Shared types, constants and helpers for the button debounce / quadrature tracker.
// No dependencies; every other file in rtl/core imports this package.
package bdqt_pkg;

   localparam int NUM_BUTTONS   = 11;
   localparam int POSITION_BITS = 8;
   localparam int TIME_BITS     = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [TIME_BITS-1:0] BUTTON_LOCK_RESET = 16'd20000;
   localparam logic [TIME_BITS-1:0] DIR_LOCK_RESET    = 16'd20000;
   localparam logic [TIME_BITS-1:0] DIR_KEEP_RESET    = 16'd18750;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [NUM_BUTTONS-1:0]   button_vec_type;
   typedef logic [POSITION_BITS-1:0] position_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BUTTON_LOCK = 2'd0,
      CSR_DIR_LOCK    = 2'd1,
      CSR_DIR_KEEP    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd2
   } direction_type;

   // Quadrature tracker timing settings
   typedef struct packed {
      time_type lock_time;
      time_type keep_time;
   } quad_cfg_type;

   typedef struct packed {
      direction_type direction;
      position_type  position;
   } quad_status_type;

   typedef struct packed {
      button_vec_type  pressed;
      button_vec_type  lamps;
      quad_status_type quad;
   } result_type;

   // Modular elapsed time strictly above the limit
   function automatic logic expired(time_type now, time_type start, time_type limit);
      time_type elapsed;
      elapsed = now - start;
      return elapsed > limit;
   endfunction

   // Raw phase pair to position in the 0,1,3,2 sequence
   function automatic logic [1:0] gray_map(logic [1:0] raw);
      logic [1:0] mapped;
      case (raw)
         2'd0:    mapped = 2'd0;
         2'd1:    mapped = 2'd1;
         2'd2:    mapped = 2'd3;
         default: mapped = 2'd2;
      endcase
      return mapped;
   endfunction

endpackage

FILE: rtl/core/bdqt_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on bdqt_pkg for field widths.
interface bdqt_req_if;
   import bdqt_pkg::*;
   logic       valid;
   logic       ready;
   logic [NUM_BUTTONS-1:0] buttons_low;
   logic [1:0] phase_raw;
   logic [TIME_BITS-1:0]   fast_time;
   logic [TIME_BITS-1:0]   slow_time;

   modport source (output valid, buttons_low, phase_raw, fast_time, slow_time,
                   input ready);
   modport sink   (input valid, buttons_low, phase_raw, fast_time, slow_time,
                   output ready);
endinterface

interface bdqt_rsp_if;
   import bdqt_pkg::*;
   logic       valid;
   logic       ready;
   logic [NUM_BUTTONS-1:0]   buttons_pressed;
   logic [NUM_BUTTONS-1:0]   lamps;
   logic [1:0] scratch_direction;
   logic [POSITION_BITS-1:0] encoder_position;

   modport source (output valid, buttons_pressed, lamps, scratch_direction,
                   encoder_position, input ready);
   modport sink   (input valid, buttons_pressed, lamps, scratch_direction,
                   encoder_position, output ready);
endinterface

FILE: rtl/core/bdqt_debounce.sv
// Lockout debouncer, one lane per button, all lanes updated in parallel.
// Depends on bdqt_pkg.
module bdqt_debounce (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  bdqt_pkg::button_vec_type pressed_raw,
   input  bdqt_pkg::time_type       fast_time,
   input  bdqt_pkg::time_type       lock_time,
   output bdqt_pkg::button_vec_type debounced_in
);
   import bdqt_pkg::*;

   button_vec_type debounced_ff;
   button_vec_type locked_ff, locked_in;
   time_type       start_ff [NUM_BUTTONS];

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         logic still_locked;
         still_locked = locked_ff[i] && !expired(fast_time, start_ff[i], lock_time);
         if (!still_locked && (debounced_ff[i] != pressed_raw[i])) begin
            debounced_in[i] = pressed_raw[i];
            locked_in[i]    = 1'b1;
         end else begin
            debounced_in[i] = debounced_ff[i];
            locked_in[i]    = still_locked;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounced_ff <= '0;
         locked_ff    <= '0;
      end else if (update) begin
         debounced_ff <= debounced_in;
         locked_ff    <= locked_in;
      end
   end

   // start time only read while the lane is locked
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (update && locked_in[i] && !locked_ff[i])
            start_ff[i] <= fast_time;
         else if (update && locked_in[i] && (debounced_in[i] != debounced_ff[i]))
            start_ff[i] <= fast_time;
      end
   end

endmodule

FILE: rtl/core/bdqt_quad.sv
// Quadrature step decoder with wrapping position count and locked direction.
// Depends on bdqt_pkg.
module bdqt_quad (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      update,
   input  logic [1:0]                phase_raw,
   input  bdqt_pkg::time_type        fast_time,
   input  bdqt_pkg::time_type        slow_time,
   input  bdqt_pkg::quad_cfg_type    cfg,
   output bdqt_pkg::quad_status_type status_in
);
   import bdqt_pkg::*;

   logic          loaded_ff;
   logic [1:0]    last_phase_ff;
   position_type  position_ff, position_in;
   direction_type direction_ff, direction_in;
   logic          dir_locked_ff, dir_locked_in;
   time_type      lock_start_ff, lock_start_in;
   time_type      hold_start_ff, hold_start_in;

   logic [1:0]    phase;
   direction_type want;

   always_comb begin
      phase         = gray_map(phase_raw);
      dir_locked_in = dir_locked_ff && !expired(fast_time, lock_start_ff, cfg.lock_time);
      direction_in  = direction_ff;
      if (direction_ff != DIR_IDLE && expired(slow_time, hold_start_ff, cfg.keep_time))
         direction_in = DIR_IDLE;
      lock_start_in = lock_start_ff;
      hold_start_in = hold_start_ff;
      position_in   = position_ff;
      want          = DIR_IDLE;

      if (loaded_ff) begin
         if (phase == last_phase_ff + 2'd1) begin
            position_in = position_ff + 1'b1;
            want        = DIR_FWD;
         end else if (phase == last_phase_ff + 2'd3) begin
            position_in = position_ff - 1'b1;
            want        = DIR_BACK;
         end
      end

      if (want != DIR_IDLE && !dir_locked_in) begin
         if (direction_in != want) begin
            direction_in  = want;
            dir_locked_in = 1'b1;
            lock_start_in = fast_time;
         end
         hold_start_in = slow_time;
      end

      status_in.direction = direction_in;
      status_in.position  = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= 1'b0;
         last_phase_ff <= '0;
         position_ff   <= '0;
         direction_ff  <= DIR_IDLE;
         dir_locked_ff <= 1'b0;
         hold_start_ff <= '0;
      end else if (update) begin
         loaded_ff     <= 1'b1;
         last_phase_ff <= phase;
         position_ff   <= position_in;
         direction_ff  <= direction_in;
         dir_locked_ff <= dir_locked_in;
         hold_start_ff <= hold_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update)
         lock_start_ff <= lock_start_in;
   end

endmodule

FILE: rtl/core/button_debounce_quadrature_tracker.sv
// Top level: debouncer and quadrature tracker behind a two-entry result buffer.
// Depends on bdqt_pkg, bdqt_if, bdqt_debounce and bdqt_quad.
//
//   channel   dir   handshake          carries
//   req_if    in    valid/ready        buttons_low, phase_raw, fast_time, slow_time
//   rsp_if    out   valid/ready        buttons_pressed, lamps, scratch_direction,
//                                      encoder_position
//   csr_*     in    write enable only  lock and keep times, index 0..2
//
// One item per cycle unless stalled; its result is registered in the result stage.
// State updates in the accept cycle, so items may follow back to back.
// A result stage plus one skid entry: input stalls only when both are full.
// Synchronous active-high reset restores default times and clears control state.
module button_debounce_quadrature_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   bdqt_req_if.sink                             req_if,
   bdqt_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_en,
   input  logic [bdqt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdqt_pkg::TIME_BITS-1:0]       csr_wdata
);
   import bdqt_pkg::*;

   time_type        button_lock_ff;
   quad_cfg_type    quad_cfg;
   time_type        dir_lock_ff;
   time_type        dir_keep_ff;

   logic            accept, take;
   button_vec_type  pressed_raw;
   button_vec_type  debounced_in;
   quad_status_type quad_in;
   result_type      result_in;

   logic            out_valid_ff, skid_valid_ff;
   result_type      out_ff, skid_ff;

   position_type    pos_prev_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         button_lock_ff <= BUTTON_LOCK_RESET;
         dir_lock_ff    <= DIR_LOCK_RESET;
         dir_keep_ff    <= DIR_KEEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BUTTON_LOCK: button_lock_ff <= csr_wdata;
            CSR_DIR_LOCK:    dir_lock_ff    <= csr_wdata;
            CSR_DIR_KEEP:    dir_keep_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign quad_cfg.lock_time = dir_lock_ff;
   assign quad_cfg.keep_time = dir_keep_ff;

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign take         = out_valid_ff && rsp_if.ready;
   assign pressed_raw  = ~req_if.buttons_low;

   bdqt_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .update       (accept),
      .pressed_raw  (pressed_raw),
      .fast_time    (req_if.fast_time),
      .lock_time    (button_lock_ff),
      .debounced_in (debounced_in)
   );

   bdqt_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .update    (accept),
      .phase_raw (req_if.phase_raw),
      .fast_time (req_if.fast_time),
      .slow_time (req_if.slow_time),
      .cfg       (quad_cfg),
      .status_in (quad_in)
   );

   assign result_in.pressed = debounced_in;
   assign result_in.lamps   = pressed_raw;
   assign result_in.quad    = quad_in;

   // result stage and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (out_valid_ff)
            skid_valid_ff <= 1'b1;
         else
            out_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff)
         out_ff <= skid_ff;
      else if (accept && (take || !out_valid_ff))
         out_ff <= result_in;
      if (accept && out_valid_ff && !take)
         skid_ff <= result_in;
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.buttons_pressed   = out_ff.pressed;
   assign rsp_if.lamps             = out_ff.lamps;
   assign rsp_if.scratch_direction = out_ff.quad.direction;
   assign rsp_if.encoder_position  = out_ff.quad.position;

   // position of the last accepted item
   always_ff @(posedge clock) begin
      if (reset)
         pos_prev_ff <= '0;
      else if (accept)
         pos_prev_ff <= quad_in.position;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty result stage");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      (accept && !out_valid_ff) |=> rsp_if.valid)
      else $error("accepted item did not reach the result stage");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.scratch_direction != 2'd3))
      else $error("unused direction code on output");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept |-> (quad_in.position == pos_prev_ff) ||
                 (quad_in.position == pos_prev_ff + 1'b1) ||
                 (quad_in.position == pos_prev_ff - 1'b1))
      else $error("position moved by more than one step");

endmodule
